// File: rtl/core/cvsd_encoder_assert.svh
// ----------------------------------------------------------------------------
// CVSD encoder assertion macros
// Short forms for the concurrent assertions used by the encoder checker.
// ----------------------------------------------------------------------------
`ifndef CVSD_ENCODER_ASSERT_SVH
`define CVSD_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CVSD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cvsd encoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CVSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cvsd encoder check failed");

`endif

// File: rtl/core/cvsd_pkg.sv
// ----------------------------------------------------------------------------
// CVSD encoder package
// Shared types, register indexes and reset values of the encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cvsd_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 17;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_FLOOR  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_CEIL   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STEP_SHRINK = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_ACC_LEAK    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_RUN_LENGTH  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ACCUM_UPPER = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_ACCUM_LOWER = 3'd6;

	// Reset values of the registers.
	localparam logic [14:0]        RST_STEP_FLOOR  = 15'd10;
	localparam logic [14:0]        RST_STEP_CEIL   = 15'd1280;
	localparam logic [16:0]        RST_STEP_SHRINK = 17'd65472;
	localparam logic [16:0]        RST_ACC_LEAK    = 17'd63488;
	localparam logic [5:0]         RST_RUN_LENGTH  = 6'd4;
	localparam logic signed [15:0] RST_ACCUM_UPPER = 16'sd32767;
	localparam logic signed [15:0] RST_ACCUM_LOWER = -16'sd32767;

	// History limits: the run length saturates at the full history width and
	// the history counter stops one past it.
	localparam logic [5:0] RUN_MAX      = 6'd32;
	localparam logic [5:0] HIST_CNT_TOP = 6'd33;

	typedef struct packed {
		logic [14:0]        step_floor;
		logic [14:0]        step_ceil;
		logic [16:0]        step_shrink;
		logic [16:0]        acc_leak;
		logic [5:0]         run_length;
		logic signed [15:0] accum_upper;
		logic signed [15:0] accum_lower;
	} cvsd_cfg_t;

endpackage

// File: rtl/core/cvsd_cfg_regs.sv
// ----------------------------------------------------------------------------
// CVSD configuration registers
// Holds the seven encoder settings, written one at a time by index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cvsd_cfg_regs
	import cvsd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cvsd_cfg_t              cfg
);

	cvsd_cfg_t cfg_q;
	logic      wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_floor  <= RST_STEP_FLOOR;
			cfg_q.step_ceil   <= RST_STEP_CEIL;
			cfg_q.step_shrink <= RST_STEP_SHRINK;
			cfg_q.acc_leak    <= RST_ACC_LEAK;
			cfg_q.run_length  <= RST_RUN_LENGTH;
			cfg_q.accum_upper <= RST_ACCUM_UPPER;
			cfg_q.accum_lower <= RST_ACCUM_LOWER;
		end else if (wr_en) begin
			unique case (cfg_index)
				REG_STEP_FLOOR:  cfg_q.step_floor  <= cfg_data[14:0];
				REG_STEP_CEIL:   cfg_q.step_ceil   <= cfg_data[14:0];
				REG_STEP_SHRINK: cfg_q.step_shrink <= cfg_data[16:0];
				REG_ACC_LEAK:    cfg_q.acc_leak    <= cfg_data[16:0];
				REG_RUN_LENGTH:  cfg_q.run_length  <= cfg_data[5:0];
				REG_ACCUM_UPPER: cfg_q.accum_upper <= $signed(cfg_data[15:0]);
				REG_ACCUM_LOWER: cfg_q.accum_lower <= $signed(cfg_data[15:0]);
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/core/cvsd_step_adapt.sv
// ----------------------------------------------------------------------------
// CVSD step size adaptation
// Works out the next step size from the current one and the bit history.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cvsd_step_adapt
	import cvsd_pkg::*;
(
	input  cvsd_cfg_t   cfg,
	input  logic [14:0] step,
	input  logic [31:0] history,
	input  logic [5:0]  hist_cnt,
	output logic [14:0] step_next
);

	logic [5:0]  run_len;
	logic [31:0] mask;
	logic [31:0] hist_masked;
	logic        run_equal;
	logic [15:0] grow_sum;
	logic [14:0] grown;
	logic [31:0] decay_prod;
	logic [32:0] decay_rnd;
	logic [16:0] decay_scl;
	logic [14:0] decay_sat;
	logic [14:0] decayed;

	assign run_len = (cfg.run_length > RUN_MAX) ? RUN_MAX : cfg.run_length;

	always_comb begin
		for (int i = 0; i < 32; i++) begin
			mask[i] = (6'(i) < run_len);
		end
	end

	assign hist_masked = history & mask;
	assign run_equal   = (hist_masked == 32'd0) || (hist_masked == mask);

	// Growth is summed one bit wider so that it cannot wrap.
	assign grow_sum = {1'b0, step} + {1'b0, cfg.step_floor};
	assign grown    = (grow_sum < {1'b0, cfg.step_ceil}) ? grow_sum[14:0] : cfg.step_ceil;

	// Decay rounds half up and saturates at the largest 15-bit step.
	assign decay_prod = {17'd0, step} * {15'd0, cfg.step_shrink};
	assign decay_rnd  = {1'b0, decay_prod} + 33'd32768;
	assign decay_scl  = decay_rnd[32:16];
	assign decay_sat  = (decay_scl > 17'd32767) ? 15'h7fff : decay_scl[14:0];
	assign decayed    = (decay_sat > cfg.step_floor) ? decay_sat : cfg.step_floor;

	always_comb begin
		priority if (hist_cnt < run_len) begin
			step_next = step;
		end else if (run_equal) begin
			step_next = grown;
		end else begin
			step_next = decayed;
		end
	end

endmodule

// File: rtl/core/cvsd_encoder.sv
// ----------------------------------------------------------------------------
// CVSD encoder
// Continuously variable slope delta encoder: one code bit per sample,
// packed eight to a byte with the earliest sample in the most significant bit.
// ----------------------------------------------------------------------------
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------
//   input    | in_valid / in_stall    | sample    (16 bit signed)
//   output   | out_valid / out_stall  | code_byte (8 bit)
//   config   | cfg_valid / cfg_ready  | cfg_index (3 bit), cfg_data (17 bit)
//
// One sample can be taken in every cycle while in_stall is low. It is registered
// on acceptance and processed when it advances; the loop (compare, add, Q1.16
// multiply, clamp) is combinational. A completed byte is loaded into the output
// register as its last sample is processed. Reset clears the state, restores the
// register defaults and empties both stages. The input stalls only when the
// registered sample completes a byte while out_stall holds the last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cvsd_encoder
	import cvsd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [15:0]     sample,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             code_byte,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam logic [2:0] LAST_BIT = 3'd7;

	cvsd_cfg_t cfg;

	// Input stage.
	logic               valid_s1;
	logic signed [15:0] sample_s1;

	// Encoder state.
	logic signed [15:0] accum_q;
	logic [14:0]        step_q;
	logic [31:0]        history_q;
	logic [5:0]         hist_cnt_q;
	logic [7:0]         byte_q;
	logic [2:0]         bit_pos_q;

	// Output register.
	logic               out_valid_q;
	logic [7:0]         code_byte_q;

	// Datapath nets.
	logic               code_bit;
	logic signed [17:0] accum_ext;
	logic signed [17:0] step_ext;
	logic signed [17:0] accum_moved;
	logic signed [35:0] accum_prod;
	logic signed [35:0] accum_rnd;
	logic signed [19:0] accum_scl;
	logic signed [19:0] upper_ext;
	logic signed [19:0] lower_ext;
	logic signed [15:0] accum_next;
	logic [14:0]        step_next;
	logic [7:0]         byte_next;
	logic               byte_done;
	logic               advance;

	cvsd_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cvsd_step_adapt u_step_adapt (
		.cfg       (cfg),
		.step      (step_q),
		.history   (history_q),
		.hist_cnt  (hist_cnt_q),
		.step_next (step_next)
	);

	// The registered sample moves on unless it completes a byte that has
	// nowhere to go yet.
	assign byte_done = (bit_pos_q == LAST_BIT);
	assign advance   = valid_s1 && (!byte_done || !out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;

	// The code bit is set when the sample is at or above the accumulator.
	assign code_bit = (sample_s1 >= accum_q);

	// The accumulator steps by the current step size, then decays with
	// half-up rounding; the arithmetic shift gives the floor for negatives.
	assign accum_ext   = {{2{accum_q[15]}}, accum_q};
	assign step_ext    = $signed({3'b000, step_q});
	assign accum_moved = code_bit ? (accum_ext + step_ext) : (accum_ext - step_ext);
	assign accum_prod  = 36'(accum_moved) * 36'($signed({1'b0, cfg.acc_leak}));
	assign accum_rnd   = accum_prod + 36'sd32768;
	assign accum_scl   = accum_rnd[35:16];

	// The upper limit is tested first, so with crossed limits it wins where both apply.
	assign upper_ext = {{4{cfg.accum_upper[15]}}, cfg.accum_upper};
	assign lower_ext = {{4{cfg.accum_lower[15]}}, cfg.accum_lower};

	always_comb begin
		priority if (accum_scl >= upper_ext) begin
			accum_next = cfg.accum_upper;
		end else if (accum_scl <= lower_ext) begin
			accum_next = cfg.accum_lower;
		end else begin
			accum_next = accum_scl[15:0];
		end
	end

	assign byte_next = {byte_q[6:0], code_bit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q    <= 16'sd0;
			step_q     <= RST_STEP_FLOOR;
			history_q  <= 32'd0;
			hist_cnt_q <= 6'd1;
			byte_q     <= 8'd0;
			bit_pos_q  <= 3'd0;
		end else if (advance) begin
			accum_q   <= accum_next;
			step_q    <= step_next;
			history_q <= {history_q[30:0], code_bit};
			if (hist_cnt_q < HIST_CNT_TOP) begin
				hist_cnt_q <= hist_cnt_q + 6'd1;
			end
			byte_q    <= byte_done ? 8'd0 : byte_next;
			bit_pos_q <= bit_pos_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && byte_done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && byte_done) begin
			code_byte_q <= byte_next;
		end
	end

	assign out_valid = out_valid_q;
	assign code_byte = code_byte_q;

endmodule

// File: rtl/core/cvsd_encoder_chk.sv
// ----------------------------------------------------------------------------
// CVSD encoder port checker
// Watches the encoder ports and checks byte accounting and stall behaviour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "cvsd_encoder_assert.svh"

module cvsd_encoder_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] code_byte
);

	logic       in_take;
	logic       out_take;
	logic       out_held;
	logic [2:0] in_mod_q;
	logic [1:0] owed_q;
	logic       byte_owed;

	assign in_take   = in_valid && !in_stall;
	assign out_take  = out_valid && !out_stall;
	assign out_held  = out_valid && out_stall;
	assign byte_owed = in_take && (in_mod_q == 3'd7);

	// Bytes owed: one per eight accepted items, less those delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_mod_q <= 3'd0;
			owed_q   <= 2'd0;
		end else begin
			if (in_take) begin
				in_mod_q <= in_mod_q + 3'd1;
			end
			owed_q <= owed_q + {1'b0, byte_owed} - {1'b0, out_take};
		end
	end

	`CVSD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_held, out_valid && $stable(code_byte))
	`CVSD_ASSERT_IMPLY(a_out_owed, clk, arst_n, out_valid, owed_q != 2'd0)
	`CVSD_ASSERT_IMPLY(a_owed_bound, clk, arst_n, 1'b1, owed_q != 2'd3)
	`CVSD_ASSERT_IMPLY(a_no_idle_stall, clk, arst_n, !out_valid, !in_stall)

endmodule

bind cvsd_encoder cvsd_encoder_chk u_cvsd_encoder_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.code_byte (code_byte)
);
